>>> src/cpu6502_effective_address_unit_assert.svh
// assertion macros for the 6502 effective address unit
`ifndef CPU6502_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`define CPU6502_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define EAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/eau_pkg.sv
// types and codes shared by the 6502 effective address unit
package eau_pkg;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // addressing mode codes
   localparam logic [3:0] MODE_ZP     = 4'd0;
   localparam logic [3:0] MODE_ZP_X   = 4'd1;
   localparam logic [3:0] MODE_ZP_Y   = 4'd2;
   localparam logic [3:0] MODE_ABS    = 4'd3;
   localparam logic [3:0] MODE_ABS_X  = 4'd4;
   localparam logic [3:0] MODE_ABS_Y  = 4'd5;
   localparam logic [3:0] MODE_IND    = 4'd6;
   localparam logic [3:0] MODE_IND_X  = 4'd7;
   localparam logic [3:0] MODE_IND_Y  = 4'd8;

   // sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOW  = 2'd1,
      PH_HIGH = 2'd2
   } phase_type;

   // result kind
   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   // request word
   typedef struct packed {
      logic       cmd;
      logic [3:0] mode;
      logic [7:0] operand_low;
      logic [7:0] operand_high;
      logic [7:0] reg_x;
      logic [7:0] reg_y;
      logic [7:0] read_data;
   } req_word_type;

   // response word
   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic        page_crossed;
   } rsp_word_type;

endpackage

>>> src/cpu6502_effective_address_unit.sv
// 6502 effective address unit: address modes, indirect pointer fetch sequencing
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------------------------------
//  req     | in  | req_valid/req_stall  | cmd, mode, operands, x, y, data
//  rsp     | out | rsp_valid/rsp_stall  | kind, address, page_crossed
//
// one word accepted per cycle while req_stall is low; each response is registered
// (input register, then response register), one 8/16-bit add per word
// reset is synchronous and clears the sequencer to idle with no response pending
// a stalled response holds; the input register keeps accepting until it is full
// words that cause no response (read data while idle) still pass through the input register
module cpu6502_effective_address_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  eau_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output eau_pkg::rsp_word_type rsp_word
);
   import eau_pkg::*;

`include "cpu6502_effective_address_unit_assert.svh"

   // input stage
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;

   // sequencer state
   phase_type    phase_ff, phase_in;
   logic [3:0]   held_mode_ff, held_mode_in;
   logic [7:0]   pointer_ff, pointer_in;
   logic [7:0]   fetched_low_ff, fetched_low_in;
   logic [7:0]   held_y_ff, held_y_in;

   // response stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // datapath
   logic         advance;
   logic         res_valid;
   rsp_word_type res_word;
   logic [8:0]   zp_x_sum;
   logic [8:0]   zp_y_sum;
   logic [15:0]  base;
   logic [15:0]  abs_x_sum;
   logic [15:0]  abs_y_sum;
   logic [7:0]   ptr_next;
   logic [15:0]  target;
   logic [15:0]  ind_y_sum;
   logic [8:0]   ind_y_low;

   // the input word moves on when the response slot is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !advance);

   // address arithmetic
   assign zp_x_sum  = {1'b0, s1_word_ff.operand_low} + {1'b0, s1_word_ff.reg_x};
   assign zp_y_sum  = {1'b0, s1_word_ff.operand_low} + {1'b0, s1_word_ff.reg_y};
   assign base      = {s1_word_ff.operand_high, s1_word_ff.operand_low};
   assign abs_x_sum = base + {8'h00, s1_word_ff.reg_x};
   assign abs_y_sum = base + {8'h00, s1_word_ff.reg_y};
   assign ptr_next  = pointer_ff + 8'd1;
   assign target    = {s1_word_ff.read_data, fetched_low_ff};
   assign ind_y_sum = target + {8'h00, held_y_ff};
   assign ind_y_low = {1'b0, fetched_low_ff} + {1'b0, held_y_ff};

   // mode decode and sequencer next state
   always_comb begin
      phase_in       = phase_ff;
      held_mode_in   = held_mode_ff;
      pointer_in     = pointer_ff;
      fetched_low_in = fetched_low_ff;
      held_y_in      = held_y_ff;
      res_valid      = 1'b0;
      res_word       = '0;
      if (s1_word_ff.cmd == CMD_START) begin
         phase_in  = PH_IDLE;
         res_valid = 1'b1;
         unique case (s1_word_ff.mode) inside
            MODE_ZP: begin
               res_word.kind    = KIND_DONE;
               res_word.address = {8'h00, s1_word_ff.operand_low};
            end
            MODE_ZP_X: begin
               res_word.kind    = KIND_DONE;
               res_word.address = {8'h00, zp_x_sum[7:0]};
            end
            MODE_ZP_Y: begin
               res_word.kind    = KIND_DONE;
               res_word.address = {8'h00, zp_y_sum[7:0]};
            end
            MODE_ABS: begin
               res_word.kind    = KIND_DONE;
               res_word.address = base;
            end
            MODE_ABS_X: begin
               res_word.kind         = KIND_DONE;
               res_word.address      = abs_x_sum;
               res_word.page_crossed = zp_x_sum[8];
            end
            MODE_ABS_Y: begin
               res_word.kind         = KIND_DONE;
               res_word.address      = abs_y_sum;
               res_word.page_crossed = zp_y_sum[8];
            end
            MODE_IND, MODE_IND_X, MODE_IND_Y: begin
               held_mode_in = s1_word_ff.mode;
               pointer_in   = (s1_word_ff.mode == MODE_IND_X) ? zp_x_sum[7:0]
                                                              : s1_word_ff.operand_low;
               held_y_in    = s1_word_ff.reg_y;
               phase_in     = PH_LOW;
               res_word.kind    = KIND_READ;
               res_word.address = {8'h00, pointer_in};
            end
            default: begin
               res_word.kind = KIND_BAD;
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_LOW: begin
               fetched_low_in   = s1_word_ff.read_data;
               phase_in         = PH_HIGH;
               res_valid        = 1'b1;
               res_word.kind    = KIND_READ;
               res_word.address = {8'h00, ptr_next};
            end
            PH_HIGH: begin
               phase_in      = PH_IDLE;
               res_valid     = 1'b1;
               res_word.kind = KIND_DONE;
               if (held_mode_ff == MODE_IND_Y) begin
                  res_word.address      = ind_y_sum;
                  res_word.page_crossed = ind_y_low[8];
               end else begin
                  res_word.address = target;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // response register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         held_mode_ff   <= 4'd0;
         pointer_ff     <= 8'd0;
         fetched_low_ff <= 8'd0;
         held_y_ff      <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            held_mode_ff   <= held_mode_in;
            pointer_ff     <= pointer_in;
            fetched_low_ff <= fetched_low_in;
            held_y_ff      <= held_y_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   `EAU_ASSERT_NOW(a_read_in_page_zero, clock, reset,
      rsp_valid_ff && (rsp_word_ff.kind == KIND_READ), rsp_word_ff.address[15:8] == 8'h00,
      "read request outside page zero")
   `EAU_ASSERT_NOW(a_cross_only_done, clock, reset,
      rsp_valid_ff && rsp_word_ff.page_crossed, rsp_word_ff.kind == KIND_DONE,
      "page crossing flagged on a non-address response")
   `EAU_ASSERT_NEXT(a_low_then_high, clock, reset,
      advance && (s1_word_ff.cmd == CMD_DATA) && (phase_ff == PH_LOW),
      (phase_ff == PH_HIGH) && rsp_valid_ff,
      "pointer low byte did not move sequencer to high phase")
   `EAU_ASSERT_NOW(a_stall_only_full, clock, reset,
      req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall,
      "input stalled without a blocked response")

endmodule
